[hdl/dmd_pkg.sv]
// dmd_pkg: shared constants, types and the month table for the minute difference unit
// no dependencies
`default_nettype none

package dmd_pkg;

   localparam int unsigned YEAR_W    = 14;
   localparam int unsigned MONTH_W   = 4;
   localparam int unsigned DAY_W     = 5;
   localparam int unsigned HOUR_W    = 5;
   localparam int unsigned MINUTE_W  = 6;
   localparam int unsigned RESULT_W  = 33;

   // internal widths, sized for the full 14-bit year range
   localparam int unsigned DAYS_W    = 23;
   localparam int unsigned HM_W      = 11;
   localparam int unsigned LINEAR_W  = RESULT_W + 1;
   localparam int unsigned PREFIX_W  = 9;

   localparam logic [YEAR_W-1:0] MAX_YEAR = YEAR_W'(9999);

   // floor(x / 100) as (x * 5243) >> 19, exact for x below 2^14
   localparam int unsigned DIV100_MUL   = 5243;
   localparam int unsigned DIV100_MUL_W = 13;
   localparam int unsigned DIV100_SHIFT = 19;
   localparam int unsigned QY_W         = 8;
   localparam int unsigned QP4_W        = 6;
   localparam int unsigned P4_W         = YEAR_W - 2;

   localparam int unsigned DAYS_PER_YEAR   = 365;
   localparam int unsigned MINUTES_PER_DAY = 1440;
   localparam int unsigned MINUTES_PER_HR  = 60;
   localparam int unsigned YEARS_PER_CENT  = 100;

   localparam logic [MONTH_W-1:0] MONTH_JAN  = MONTH_W'(1);
   localparam logic [MONTH_W-1:0] MONTH_FEB  = MONTH_W'(2);
   localparam logic [MONTH_W-1:0] MONTH_DEC  = MONTH_W'(12);

   typedef struct packed {
      logic stage_a;
      logic stage_b;
      logic stage_c;
   } stage_en_type;

   // days before month index 0..12 of a common year
   function automatic logic [PREFIX_W-1:0] month_prefix(input logic [MONTH_W-1:0] idx);
      logic [PREFIX_W-1:0] res;
      case (idx)
         4'd0:    res = 9'd0;
         4'd1:    res = 9'd31;
         4'd2:    res = 9'd59;
         4'd3:    res = 9'd90;
         4'd4:    res = 9'd120;
         4'd5:    res = 9'd151;
         4'd6:    res = 9'd181;
         4'd7:    res = 9'd212;
         4'd8:    res = 9'd243;
         4'd9:    res = 9'd273;
         4'd10:   res = 9'd304;
         4'd11:   res = 9'd334;
         default: res = 9'd365;
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

[hdl/datetime_minute_difference_unit.sv]
// datetime_minute_difference_unit: top level, two date-time lanes and a merge stage
// depends on dmd_pkg, dmd_lane, dmd_merge
// an accepted transaction moves through the three lane stages and the merge register, and
// rsp_valid is then high for one cycle; no new transaction is taken while one is in the
// lanes, and start is taken again in the cycle that shows the result
// reset (synchronous, active high) clears the stage valid chain and rsp_valid; busy is low
// out of reset and the receiver cannot stall the result
`default_nettype none

module datetime_minute_difference_unit
   import dmd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [YEAR_W-1:0]     req_first_year,
   input  wire logic [MONTH_W-1:0]    req_first_month,
   input  wire logic [DAY_W-1:0]      req_first_day,
   input  wire logic [HOUR_W-1:0]     req_first_hour,
   input  wire logic [MINUTE_W-1:0]   req_first_minute,
   input  wire logic [YEAR_W-1:0]     req_second_year,
   input  wire logic [MONTH_W-1:0]    req_second_month,
   input  wire logic [DAY_W-1:0]      req_second_day,
   input  wire logic [HOUR_W-1:0]     req_second_hour,
   input  wire logic [MINUTE_W-1:0]   req_second_minute,
   output logic                       rsp_valid,
   output logic [RESULT_W-1:0]        rsp_minutes_apart
);

   // valid chain that follows the single transaction in flight
   logic          accept;
   logic          valid_a_ff;
   logic          valid_b_ff;
   logic          valid_c_ff;
   logic          rsp_valid_ff;
   stage_en_type  stage_en;

   // linear minute counts from each lane
   logic [LINEAR_W-1:0] first_minutes;
   logic [LINEAR_W-1:0] second_minutes;

   // a new transaction only enters once the previous one has left the lanes
   assign busy   = valid_a_ff | valid_b_ff | valid_c_ff;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff   <= 1'b0;
         valid_b_ff   <= 1'b0;
         valid_c_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_a_ff   <= accept;
         valid_b_ff   <= valid_a_ff;
         valid_c_ff   <= valid_b_ff;
         rsp_valid_ff <= valid_c_ff;
      end
   end

   // each stage loads only when its predecessor holds the transaction
   always_comb begin
      stage_en.stage_a = accept;
      stage_en.stage_b = valid_a_ff;
      stage_en.stage_c = valid_b_ff;
   end

   // lane for the first date-time
   dmd_lane u_lane_first (
      .clock          (clock),
      .stage_en       (stage_en),
      .year           (req_first_year),
      .month          (req_first_month),
      .day            (req_first_day),
      .hour           (req_first_hour),
      .minute         (req_first_minute),
      .linear_minutes (first_minutes)
   );

   // lane for the second date-time
   dmd_lane u_lane_second (
      .clock          (clock),
      .stage_en       (stage_en),
      .year           (req_second_year),
      .month          (req_second_month),
      .day            (req_second_day),
      .hour           (req_second_hour),
      .minute         (req_second_minute),
      .linear_minutes (second_minutes)
   );

   // merge: magnitude of the difference, held while rsp_valid is shown
   dmd_merge u_merge (
      .clock          (clock),
      .load           (valid_c_ff),
      .first_minutes  (first_minutes),
      .second_minutes (second_minutes),
      .minutes_apart  (rsp_minutes_apart)
   );

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

[hdl/dmd_lane.sv]
// dmd_lane: maps one date-time to a linear minute count in three register stages
// depends on dmd_pkg
`default_nettype none

module dmd_lane
   import dmd_pkg::*;
(
   input  wire logic                 clock,
   input  wire stage_en_type         stage_en,
   input  wire logic [YEAR_W-1:0]    year,
   input  wire logic [MONTH_W-1:0]   month,
   input  wire logic [DAY_W-1:0]     day,
   input  wire logic [HOUR_W-1:0]    hour,
   input  wire logic [MINUTE_W-1:0]  minute,
   output logic [LINEAR_W-1:0]       linear_minutes
);

   // stage a: clamp, reciprocal divisions by 100
   logic [YEAR_W-1:0]      year_clamp;
   logic [YEAR_W-1:0]      year_prev;
   logic [P4_W-1:0]        p4;
   logic [YEAR_W+DIV100_MUL_W-1:0] prod_y;
   logic [YEAR_W+DIV100_MUL_W-1:0] prod_p;
   logic [P4_W+DIV100_MUL_W-1:0]   prod_p4;
   logic [HM_W-1:0]        hm_in;

   logic [YEAR_W-1:0]      year_a_ff;
   logic [QY_W-1:0]        qy_a_ff;
   logic [QY_W-1:0]        qp_a_ff;
   logic [QP4_W-1:0]       qp4_a_ff;
   logic [P4_W-1:0]        p4_a_ff;
   logic [MONTH_W-1:0]     month_a_ff;
   logic [DAY_W-1:0]       day_a_ff;
   logic [HM_W-1:0]        hm_a_ff;

   // stage b: day count
   logic                   leap;
   logic [MONTH_W-1:0]     month_idx;
   logic [DAYS_W-1:0]      days_before;
   logic [DAYS_W-1:0]      days_in;
   logic [DAYS_W-1:0]      days_b_ff;
   logic [HM_W-1:0]        hm_b_ff;

   // stage c: minute count
   logic [LINEAR_W-1:0]    minutes_in;
   logic [LINEAR_W-1:0]    minutes_c_ff;

   always_comb begin
      year_clamp = (year > MAX_YEAR) ? MAX_YEAR : year;
      year_prev  = year_clamp - YEAR_W'(1);
      p4         = year_prev[YEAR_W-1:2];
      prod_y     = (YEAR_W+DIV100_MUL_W)'(year_clamp) * (YEAR_W+DIV100_MUL_W)'(DIV100_MUL);
      prod_p     = (YEAR_W+DIV100_MUL_W)'(year_prev) * (YEAR_W+DIV100_MUL_W)'(DIV100_MUL);
      prod_p4    = (P4_W+DIV100_MUL_W)'(p4) * (P4_W+DIV100_MUL_W)'(DIV100_MUL);
      hm_in      = HM_W'(hour) * HM_W'(MINUTES_PER_HR) + HM_W'(minute);
   end

   always_ff @(posedge clock) begin
      if (stage_en.stage_a) begin
         year_a_ff  <= year_clamp;
         qy_a_ff    <= prod_y[DIV100_SHIFT +: QY_W];
         qp_a_ff    <= prod_p[DIV100_SHIFT +: QY_W];
         qp4_a_ff   <= prod_p4[DIV100_SHIFT +: QP4_W];
         p4_a_ff    <= p4;
         month_a_ff <= month;
         day_a_ff   <= day;
         hm_a_ff    <= hm_in;
      end
   end

   always_comb begin
      // divisible by 4, and not a century unless the century count divides by 4
      leap = (year_a_ff[1:0] == 2'b00) &&
             ((year_a_ff != YEAR_W'(qy_a_ff) * YEAR_W'(YEARS_PER_CENT)) ||
              (qy_a_ff[1:0] == 2'b00));
      if (month_a_ff == '0) begin
         month_idx = '0;
      end else if (month_a_ff > MONTH_DEC) begin
         month_idx = MONTH_DEC;
      end else begin
         month_idx = month_a_ff - MONTH_JAN;
      end
      // year 0 is a leap year, then the leap years among 1..year-1
      if (year_a_ff == '0) begin
         days_before = '0;
      end else begin
         days_before = DAYS_W'(year_a_ff) * DAYS_W'(DAYS_PER_YEAR) + DAYS_W'(1)
                     + DAYS_W'(p4_a_ff) - DAYS_W'(qp_a_ff) + DAYS_W'(qp4_a_ff);
      end
      // day counted from one so the count never goes negative; both lanes share the offset
      days_in = days_before + DAYS_W'(month_prefix(month_idx)) + DAYS_W'(day_a_ff)
              + DAYS_W'((month_a_ff > MONTH_FEB) && leap);
   end

   always_ff @(posedge clock) begin
      if (stage_en.stage_b) begin
         days_b_ff <= days_in;
         hm_b_ff   <= hm_a_ff;
      end
   end

   assign minutes_in = LINEAR_W'(days_b_ff) * LINEAR_W'(MINUTES_PER_DAY) + LINEAR_W'(hm_b_ff);

   always_ff @(posedge clock) begin
      if (stage_en.stage_c) begin
         minutes_c_ff <= minutes_in;
      end
   end

   assign linear_minutes = minutes_c_ff;

endmodule

`default_nettype wire

[hdl/dmd_merge.sv]
// dmd_merge: absolute difference of the two lane counts, saturated, into the result register
// depends on dmd_pkg
`default_nettype none

module dmd_merge
   import dmd_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 load,
   input  wire logic [LINEAR_W-1:0]  first_minutes,
   input  wire logic [LINEAR_W-1:0]  second_minutes,
   output logic [RESULT_W-1:0]       minutes_apart
);

   logic [LINEAR_W-1:0] diff;
   logic [RESULT_W-1:0] minutes_apart_in;
   logic [RESULT_W-1:0] minutes_apart_ff;

   always_comb begin
      if (first_minutes >= second_minutes) begin
         diff = first_minutes - second_minutes;
      end else begin
         diff = second_minutes - first_minutes;
      end
      // clip to the result range
      minutes_apart_in = diff[LINEAR_W-1] ? '1 : diff[RESULT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         minutes_apart_ff <= minutes_apart_in;
      end
   end

   assign minutes_apart = minutes_apart_ff;

endmodule

`default_nettype wire

[hdl/dmd_checker.sv]
// dmd_checker: port-level checks on the minute difference unit, bound to the top level
// depends on dmd_pkg and datetime_minute_difference_unit
`default_nettype none

module dmd_checker
   import dmd_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic                 busy,
   input  wire logic                 rsp_valid,
   input  wire logic [RESULT_W-1:0]  rsp_minutes_apart
);

   // every accepted transaction gives its result strobe
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_valid)
      else $error("result missing four cycles after an accepted transaction");

   // after acceptance the unit reports busy
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after acceptance");

   // a result is a single-cycle strobe
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("rsp_valid held longer than one cycle");

   // the result only appears once the lanes are drained
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && !$isunknown(rsp_minutes_apart)))
      else $error("result shown while busy or unknown");

endmodule

bind datetime_minute_difference_unit dmd_checker u_dmd_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_minutes_apart (rsp_minutes_apart)
);

`default_nettype wire

[bench/datetime_minute_difference_unit_tb.sv]
`timescale 1ns / 1ps
// datetime_minute_difference_unit_tb: self-checking bench for the minute difference unit,
// directed corner pairs then random pairs, each result checked against an in-bench predictor
// depends on dmd_pkg and datetime_minute_difference_unit

module datetime_minute_difference_unit_tb;
   import dmd_pkg::*;

   // one date-time as the block sees it, at the port widths
   typedef struct packed {
      logic [YEAR_W-1:0]   year;
      logic [MONTH_W-1:0]  month;
      logic [DAY_W-1:0]    day;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
   } stamp_type;

   // one transaction: the pair whose distance is wanted
   typedef struct packed {
      stamp_type lhs;
      stamp_type rhs;
   } stamp_pair_type;

   localparam int                    RANDOM_PAIRS = 1350;
   localparam int                    CYCLE_LIMIT  = 250000;
   localparam int                    DRAIN_CYCLES = 10;
   localparam longint unsigned       RESULT_SAT   = (64'd1 << RESULT_W) - 1;

   // cumulative days at the start of each month of a common year, index 12 is the whole year
   int cum_days [0:12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365};
   // years that sit on the leap rule's edges
   int edge_years [0:8] = '{0, 4, 100, 400, 1900, 2000, 2100, 9996, 9999};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;

   logic [YEAR_W-1:0]   req_first_year    = '0;
   logic [MONTH_W-1:0]  req_first_month   = '0;
   logic [DAY_W-1:0]    req_first_day     = '0;
   logic [HOUR_W-1:0]   req_first_hour    = '0;
   logic [MINUTE_W-1:0] req_first_minute  = '0;
   logic [YEAR_W-1:0]   req_second_year   = '0;
   logic [MONTH_W-1:0]  req_second_month  = '0;
   logic [DAY_W-1:0]    req_second_day    = '0;
   logic [HOUR_W-1:0]   req_second_hour   = '0;
   logic [MINUTE_W-1:0] req_second_minute = '0;

   logic                rsp_valid;
   logic [RESULT_W-1:0] rsp_minutes_apart;

   stamp_pair_type      pending_pairs [$];   // pairs waiting to be offered
   logic [RESULT_W-1:0] minutes_apart_q [$]; // distances owed by the block, oldest first
   stamp_pair_type      held_pair;           // pair currently on the request ports

   int total_items    = 0;
   int directed_count = 0;
   int sent_count     = 0;
   int checked_count  = 0;
   int fail_count     = 0;
   int cycle_count    = 0;

   datetime_minute_difference_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_first_year    (req_first_year),
      .req_first_month   (req_first_month),
      .req_first_day     (req_first_day),
      .req_first_hour    (req_first_hour),
      .req_first_minute  (req_first_minute),
      .req_second_year   (req_second_year),
      .req_second_month  (req_second_month),
      .req_second_day    (req_second_day),
      .req_second_hour   (req_second_hour),
      .req_second_minute (req_second_minute),
      .rsp_valid         (rsp_valid),
      .rsp_minutes_apart (rsp_minutes_apart)
   );

   // ---------------------------------------------------------------- predictor

   function automatic bit leap_year_of(input longint unsigned yr);
      return (yr % 4 == 0) && ((yr % YEARS_PER_CENT != 0) || (yr % 400 == 0));
   endfunction

   // linear minute count from the start of year zero
   function automatic longint stamp_minutes(input stamp_type s);
      longint unsigned yr;
      int unsigned     mon;
      longint          days;
      yr  = (s.year > MAX_YEAR) ? MAX_YEAR : s.year;
      // month zero behaves as january, anything past december as the whole year
      if (s.month == '0)
         mon = MONTH_JAN;
      else if (s.month > MONTH_DEC)
         mon = MONTH_DEC + 1;
      else
         mon = s.month;
      // year zero counts as leap, then the leap years among 1 .. yr-1
      if (yr == 0)
         days = 0;
      else
         days = longint'(DAYS_PER_YEAR * yr + 1 + (yr - 1) / 4
                         - (yr - 1) / YEARS_PER_CENT + (yr - 1) / 400);
      days += cum_days[mon - 1];
      if (mon > MONTH_FEB && leap_year_of(yr))
         days += 1;
      // day zero lands on the last day of the month before
      days += longint'(s.day) - 1;
      return days * MINUTES_PER_DAY + longint'(s.hour) * MINUTES_PER_HR + longint'(s.minute);
   endfunction

   function automatic logic [RESULT_W-1:0] predict_minutes_apart(input stamp_pair_type p);
      longint          a;
      longint          b;
      longint unsigned d;
      a = stamp_minutes(p.lhs);
      b = stamp_minutes(p.rhs);
      d = (a >= b) ? longint'(a - b) : longint'(b - a);
      if (d > RESULT_SAT)
         d = RESULT_SAT;
      return d[RESULT_W-1:0];
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   function automatic stamp_type mk(input int yr, input int mo, input int dy, input int hr,
                                    input int mi);
      stamp_type s;
      s.year   = yr[YEAR_W-1:0];
      s.month  = mo[MONTH_W-1:0];
      s.day    = dy[DAY_W-1:0];
      s.hour   = hr[HOUR_W-1:0];
      s.minute = mi[MINUTE_W-1:0];
      return s;
   endfunction

   function automatic int month_days(input int yr, input int mo);
      return cum_days[mo] - cum_days[mo - 1]
             + ((mo == MONTH_FEB && leap_year_of(yr)) ? 1 : 0);
   endfunction

   // a calendar-correct date-time, biased towards the leap rule's edge years
   function automatic stamp_type rand_stamp();
      int yr;
      int mo;
      if ($urandom_range(7) == 0)
         yr = edge_years[$urandom_range(8)];
      else
         yr = $urandom_range(9999);
      mo = $urandom_range(12, 1);
      return mk(yr, mo, $urandom_range(month_days(yr, mo), 1), $urandom_range(23),
                $urandom_range(59));
   endfunction

   // any bit pattern at all on the fields
   function automatic stamp_type raw_stamp();
      return mk($urandom, $urandom, $urandom, $urandom, $urandom);
   endfunction

   task automatic add_pair(input stamp_type a, input stamp_type b);
      stamp_pair_type p;
      p.lhs = a;
      p.rhs = b;
      pending_pairs.push_back(p);
   endtask

   // ---------------------------------------------------------------- clock and reset

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------- driver
   // a transaction goes when start is high and busy low at the edge; start then either
   // carries the next pair straight away or drops for a random gap

   always @(posedge clock) begin : drive_proc
      stamp_pair_type nxt;
      logic           offer;
      int             idle_pct;
      if (reset) begin
         start <= 1'b0;
      end else begin
         offer = start;
         if (start && !busy) begin
            minutes_apart_q.push_back(predict_minutes_apart(held_pair));
            sent_count++;
            offer = 1'b0;
         end
         // sender idling: 31 percent, then 71 percent, then flat out
         if (sent_count < total_items / 3)
            idle_pct = 31;
         else if (sent_count < 2 * total_items / 3)
            idle_pct = 71;
         else
            idle_pct = 0;
         if (!offer && pending_pairs.size() > 0 && $urandom_range(99) >= idle_pct) begin
            nxt       = pending_pairs.pop_front();
            held_pair = nxt;
            offer     = 1'b1;
            req_first_year    <= nxt.lhs.year;
            req_first_month   <= nxt.lhs.month;
            req_first_day     <= nxt.lhs.day;
            req_first_hour    <= nxt.lhs.hour;
            req_first_minute  <= nxt.lhs.minute;
            req_second_year   <= nxt.rhs.year;
            req_second_month  <= nxt.rhs.month;
            req_second_day    <= nxt.rhs.day;
            req_second_hour   <= nxt.rhs.hour;
            req_second_minute <= nxt.rhs.minute;
         end
         start <= offer;
      end
   end

   // ---------------------------------------------------------------- monitor
   // each strobe is matched against the oldest owed distance

   always @(posedge clock) begin : check_proc
      logic [RESULT_W-1:0] want;
      if (!reset && rsp_valid) begin
         if (minutes_apart_q.size() == 0) begin
            $error("minutes_apart: result %0d with no transaction outstanding",
                   rsp_minutes_apart);
            fail_count++;
         end else begin
            want = minutes_apart_q.pop_front();
            checked_count++;
            if (rsp_minutes_apart !== want) begin
               $error("minutes_apart mismatch: expected %0d, actual %0d", want,
                      rsp_minutes_apart);
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d pairs unsent, %0d results owed",
                  cycle_count, pending_pairs.size(), minutes_apart_q.size());
         $display("status: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin : main_proc
      stamp_type a;
      stamp_type b;
      int        kind;
      int        steps [0:4];
      steps = '{0, 1, 4, 100, 400};

      // directed corners
      add_pair(mk(2024, 3, 15, 12, 30), mk(2024, 3, 15, 12, 30));   // same instant
      add_pair(mk(0, 1, 1, 0, 0), mk(9999, 12, 31, 23, 59));        // widest legal span
      add_pair(mk(9999, 12, 31, 23, 59), mk(0, 1, 1, 0, 0));        // same, order swapped
      add_pair(mk(2000, 2, 28, 23, 59), mk(2000, 3, 1, 0, 0));      // leap century
      add_pair(mk(1900, 2, 28, 23, 59), mk(1900, 3, 1, 0, 0));      // common century
      add_pair(mk(2023, 12, 31, 23, 59), mk(2024, 1, 1, 0, 0));     // year rollover
      add_pair(mk(0, 2, 29, 0, 0), mk(0, 3, 1, 0, 0));              // year zero is leap
      add_pair(mk(2001, 2, 31, 0, 0), mk(2001, 3, 3, 0, 0));        // day past month end
      add_pair(mk(2010, 5, 0, 0, 0), mk(2010, 4, 30, 0, 0));        // day zero
      add_pair(mk(2010, 5, 1, 31, 63), mk(2010, 5, 1, 0, 0));       // hour and minute overrange
      add_pair(mk(2015, 0, 10, 8, 0), mk(2015, 1, 10, 8, 0));       // month zero
      add_pair(mk(2016, 13, 1, 0, 0), mk(2017, 1, 1, 0, 0));        // month past december
      add_pair(mk(2016, 15, 31, 31, 63), mk(1, 1, 1, 0, 0));
      add_pair(mk(16383, 6, 1, 0, 0), mk(9999, 6, 1, 0, 0));        // year clamped
      add_pair(mk(10000, 1, 1, 0, 0), mk(0, 1, 1, 0, 0));
      add_pair(mk(16383, 15, 31, 31, 63), mk(0, 0, 0, 0, 0));       // all ones against zeros
      add_pair(mk(2100, 12, 31, 23, 59), mk(2101, 1, 1, 0, 0));
      add_pair(mk(1600, 2, 29, 12, 0), mk(2000, 2, 29, 12, 0));     // full 400-year cycle
      add_pair(mk(1999, 12, 31, 0, 0), mk(2000, 12, 31, 0, 0));
      add_pair(mk(9999, 12, 31, 23, 59), mk(9999, 12, 31, 23, 58)); // one minute
      directed_count = pending_pairs.size();

      // random pairs: mostly real calendar dates, some near neighbours, some raw bits
      repeat (RANDOM_PAIRS) begin
         kind = $urandom_range(9);
         a    = rand_stamp();
         if (kind < 6) begin
            b = rand_stamp();
         end else if (kind < 8) begin
            b = a;
            case ($urandom_range(3))
               0: begin
                  b.minute = MINUTE_W'($urandom_range(59));
                  b.hour   = HOUR_W'($urandom_range(23));
               end
               1: b.day = DAY_W'($urandom_range(28, 1));
               2: b.month = MONTH_W'($urandom_range(12, 1));
               default: begin
                  b.year = YEAR_W'((a.year + steps[$urandom_range(4)]) % 10000);
                  if (b.day > 28)
                     b.day = DAY_W'(28);
               end
            endcase
         end else begin
            b = raw_stamp();
            if ($urandom_range(1))
               a = raw_stamp();
         end
         if ($urandom_range(1))
            add_pair(a, b);
         else
            add_pair(b, a);
      end
      total_items = pending_pairs.size();

      // wait for every pair to be taken and every distance to come back
      @(posedge clock);
      while (pending_pairs.size() > 0 || start || minutes_apart_q.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("checked %0d of %0d transactions (%0d directed corners, %0d random pairs)",
               checked_count, total_items, directed_count, total_items - directed_count);
      $display("sender idled at 31 and 71 percent, then ran flat out; %0d cycles, %0d errors",
               cycle_count, fail_count);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
